[hdl/blir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blir_pkg
// Shared types and codes for the bounded list: request kinds, status codes,
// stream word widths and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package blir_pkg;

  // Stream word layout
  localparam int IN_TDATA_W  = 40;  // value[31:0], position[39:32]
  localparam int IN_TUSER_W  = 3;   // action[2:0]
  localparam int OUT_TDATA_W = 40;  // removed_value[31:0], entry_count[36:32], zero pad
  localparam int OUT_TUSER_W = 2;   // status[1:0]

  localparam int FIELD_VALUE_W = 32;
  localparam int FIELD_POS_W   = 8;
  localparam int FIELD_COUNT_W = 5;

  // Request kinds
  localparam logic [2:0] ACT_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK   = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT   = 3'd2;
  localparam logic [2:0] ACT_REMOVE_LAST = 3'd3;
  localparam logic [2:0] ACT_REMOVE_AT   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BOUNDS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Value returned by a failed removal
  localparam logic [FIELD_VALUE_W-1:0] FAIL_VALUE = 32'hFFFF_FFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_req;   // latch the incoming word
    logic exec;       // decide, update pointers, issue first memory access
    logic capture;    // take the removed value from the read register
    logic shift_rd;   // read the entry behind the gap
    logic shift_wr;   // write it into the gap and advance
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_read;  // request removes an entry
    logic more;       // entries remain to be moved down
    logic more_after; // entries remain after the current move
  } stat_t;

endpackage

[hdl/blir_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blir_ctrl
// Sequencer for the bounded list: accepts one word, steps the datapath
// through decision, read-back and gap closing, then hands the result on.
// ----------------------------------------------------------------------------
module blir_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  blir_pkg::stat_t stat_i,
  output blir_pkg::cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_CAPTURE  = 6'b000100,
    S_SHIFT_RD = 6'b001000,
    S_SHIFT_WR = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_read ? S_CAPTURE : S_FINISH;
      end
      S_CAPTURE: begin
        cmd_o.capture = 1'b1;
        state_d       = stat_i.more ? S_SHIFT_RD : S_FINISH;
      end
      S_SHIFT_RD: begin
        cmd_o.shift_rd = 1'b1;
        state_d        = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = stat_i.more_after ? S_SHIFT_RD : S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the output word until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/blir_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blir_datapath
// Entry memory kept as a circular buffer with head pointer and count,
// request and result registers, and the output word register.
// ----------------------------------------------------------------------------
module blir_datapath #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  blir_pkg::cmd_t                     cmd_i,
  output blir_pkg::stat_t                    stat_o,
  input  logic [blir_pkg::IN_TDATA_W-1:0]    in_tdata_i,   // value, position
  input  logic [blir_pkg::IN_TUSER_W-1:0]    in_tuser_i,   // action
  output logic [blir_pkg::OUT_TDATA_W-1:0]   out_tdata_o,  // removed_value, entry_count, pad
  output logic [blir_pkg::OUT_TUSER_W-1:0]   out_tuser_o   // status
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > blir_pkg::FIELD_POS_W) ? CNT_W : blir_pkg::FIELD_POS_W;
  localparam int EXT_W = 2 * blir_pkg::FIELD_VALUE_W;
  localparam int PAD_W = blir_pkg::OUT_TDATA_W - blir_pkg::FIELD_VALUE_W
                         - blir_pkg::FIELD_COUNT_W;

  // Map a logical position onto a memory address
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      j_q, j_d;
  logic [2:0]            act_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [blir_pkg::FIELD_POS_W-1:0] pos_q;
  logic [blir_pkg::FIELD_VALUE_W-1:0] res_value_q, res_value_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [VALUE_BITS-1:0] rd_data_q;
  logic [blir_pkg::FIELD_VALUE_W-1:0] out_value_q;
  logic [1:0]            out_status_q;
  logic [blir_pkg::FIELD_COUNT_W-1:0] out_count_q;

  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [EXT_W-1:0]      in_val_ext;
  logic                  full, empty, pos_ok;

  assign in_val_ext = {{blir_pkg::FIELD_VALUE_W{in_tdata_i[blir_pkg::FIELD_VALUE_W-1]}},
                       in_tdata_i[blir_pkg::FIELD_VALUE_W-1:0]};

  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);
  assign pos_ok = (CMP_W'(pos_q) < CMP_W'(count_q));

  // Controller status
  always_comb begin
    stat_o = '0;
    case (act_q)
      blir_pkg::ACT_POP_FRONT,
      blir_pkg::ACT_REMOVE_LAST: stat_o.need_read = !empty;
      blir_pkg::ACT_REMOVE_AT:   stat_o.need_read = !empty && pos_ok;
      default:                   stat_o.need_read = 1'b0;
    endcase
    stat_o.more       = (act_q == blir_pkg::ACT_REMOVE_AT)
                        && ((CNT_W + 1)'(j_q) < (CNT_W + 1)'(count_q));
    stat_o.more_after = ((CNT_W + 1)'(j_q) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(count_q);
  end

  // Decide, update pointers and drive the memory port
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    j_d          = j_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = head_q;
    mem_wdata    = val_q;
    mem_re       = 1'b0;
    mem_raddr    = head_q;

    if (cmd_i.exec) begin
      res_value_d  = '0;
      res_status_d = blir_pkg::ST_OK;
      case (act_q)
        blir_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            res_status_d = blir_pkg::ST_FULL;
          end else begin
            head_d    = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
            mem_we    = 1'b1;
            mem_waddr = head_d;
            count_d   = count_q + CNT_W'(1);
          end
        end
        blir_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            res_status_d = blir_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = phys(head_q, IDX_W'(count_q));
            count_d   = count_q + CNT_W'(1);
          end
        end
        blir_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            res_value_d  = blir_pkg::FAIL_VALUE;
            res_status_d = blir_pkg::ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = head_q;
            head_d    = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);
            count_d   = count_q - CNT_W'(1);
          end
        end
        blir_pkg::ACT_REMOVE_LAST: begin
          if (empty) begin
            res_value_d  = blir_pkg::FAIL_VALUE;
            res_status_d = blir_pkg::ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = phys(head_q, IDX_W'(count_q - CNT_W'(1)));
            count_d   = count_q - CNT_W'(1);
          end
        end
        blir_pkg::ACT_REMOVE_AT: begin
          if (empty) begin
            res_value_d  = blir_pkg::FAIL_VALUE;
            res_status_d = blir_pkg::ST_EMPTY;
          end else if (!pos_ok) begin
            res_value_d  = blir_pkg::FAIL_VALUE;
            res_status_d = blir_pkg::ST_BOUNDS;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = phys(head_q, IDX_W'(pos_q));
            j_d       = IDX_W'(pos_q);
            count_d   = count_q - CNT_W'(1);
          end
        end
        default: begin
          res_value_d  = '0;
          res_status_d = blir_pkg::ST_OK;
        end
      endcase
    end

    if (cmd_i.capture) begin
      res_value_d = blir_pkg::FIELD_VALUE_W'(rd_data_q);
    end

    // Close the gap one entry at a time
    if (cmd_i.shift_rd) begin
      mem_re    = 1'b1;
      mem_raddr = phys(head_q, j_q + IDX_W'(1));
    end
    if (cmd_i.shift_wr) begin
      mem_we    = 1'b1;
      mem_waddr = phys(head_q, j_q);
      mem_wdata = rd_data_q;
      j_d       = j_q + IDX_W'(1);
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // List pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Request, result and output word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      act_q <= in_tuser_i;
      val_q <= in_val_ext[VALUE_BITS-1:0];
      pos_q <= in_tdata_i[blir_pkg::FIELD_VALUE_W +: blir_pkg::FIELD_POS_W];
    end
    j_q          <= j_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (cmd_i.load_out) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_count_q  <= blir_pkg::FIELD_COUNT_W'(count_q);
    end
  end

  assign out_tdata_o = {{PAD_W{1'b0}}, out_count_q, out_value_q};
  assign out_tuser_o = out_status_q;

endmodule

[hdl/bounded_list_with_index_remove.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_with_index_remove
// Bounded ordered list of signed values with push front/back, pop front,
// remove last and remove at position, one result word per request.
// ----------------------------------------------------------------------------
// Entries sit in a memory with one write and one read port, used one access
// at a time as a circular buffer, so pushes, pop front and remove last move
// no data. Pushes, errors and unused codes pass from acceptance through the
// decision to the finish; pop front and remove last add one memory read, and
// remove at position then reads every entry behind the removed one and
// writes it back one place lower, one memory access at a time. The result
// waits in an output register, so a new request is taken while the previous
// result is still unclaimed; the block only stalls at the end of a request
// while that register is full. The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module bounded_list_with_index_remove #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [blir_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // value[31:0], position[39:32]
  input  logic [blir_pkg::IN_TUSER_W-1:0]   s_axis_tuser,   // action[2:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [blir_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // removed_value[31:0],
                                                            // entry_count[36:32], zero[39:37]
  output logic [blir_pkg::OUT_TUSER_W-1:0]  m_axis_tuser    // status[1:0]
);

  blir_pkg::cmd_t  cmd;
  blir_pkg::stat_t stat;

  blir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  blir_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

  // At most one datapath step per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take_req, cmd.exec, cmd.capture, cmd.shift_rd, cmd.shift_wr,
              cmd.load_out}))
    else $error("more than one datapath command at once");

  // A latched word is decided in the next cycle
  a_take_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take_req |=> cmd.exec)
    else $error("accepted word not executed");

  // No word is taken while a request is in progress
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cmd.exec || cmd.capture || cmd.shift_rd || cmd.shift_wr))
    else $error("input ready while a request is in progress");

  // A loaded result is presented in the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule
